// File: hw/rtl/fct_pkg.sv
// Shared constants, request codes and the control struct for the frustum cull test core.
package fct_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int NORMAL_FRAC = 14;
	localparam int COEF_W = 16;
	localparam int PLANE_W = 4 * COEF_W;
	localparam int CFG_INDEX_W = 3;
	localparam int COORD_WIDTH_DEF = 16;

	// Primitive kinds; any other code is tested as a point
	localparam logic [1:0] REQ_POINT = 2'd0;
	localparam logic [1:0] REQ_SPHERE = 2'd1;
	localparam logic [1:0] REQ_BOX = 2'd2;

	// Control that moves from cell to cell with each request
	typedef struct packed {
		logic vld;
		logic visible;
	} ctl_t;

endpackage

// File: hw/rtl/fct_cell.sv
// One plane cell: holds a plane, tests the passing request against it, passes it on.
module fct_cell #(
	parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fct_pkg::PLANE_W-1:0]         cfg_data,
	input  fct_pkg::ctl_t                       in_ctl,
	input  logic [1:0]                          in_kind,
	input  logic signed [COORD_WIDTH-1:0]       in_x,
	input  logic signed [COORD_WIDTH-1:0]       in_y,
	input  logic signed [COORD_WIDTH-1:0]       in_z,
	input  logic [COORD_WIDTH-2:0]              in_r,
	input  logic [COORD_WIDTH-2:0]              in_hx,
	input  logic [COORD_WIDTH-2:0]              in_hy,
	input  logic [COORD_WIDTH-2:0]              in_hz,
	output fct_pkg::ctl_t                       out_ctl,
	output logic [1:0]                          out_kind,
	output logic signed [COORD_WIDTH-1:0]       out_x,
	output logic signed [COORD_WIDTH-1:0]       out_y,
	output logic signed [COORD_WIDTH-1:0]       out_z,
	output logic [COORD_WIDTH-2:0]              out_r,
	output logic [COORD_WIDTH-2:0]              out_hx,
	output logic [COORD_WIDTH-2:0]              out_hy,
	output logic [COORD_WIDTH-2:0]              out_hz
);

	localparam int PW = COORD_WIDTH + fct_pkg::COEF_W;
	localparam int SW = (COORD_WIDTH + 20 > 34) ? COORD_WIDTH + 20 : 34;
	localparam int CW = fct_pkg::COEF_W;

	logic [fct_pkg::PLANE_W-1:0] plane_q;

	logic signed [CW-1:0] nx, ny, nz, dofs;
	logic [CW:0] ax, ay, az;
	logic signed [PW-1:0] px, py, pz;
	logic [PW-1:0] bx, by, bz;

	fct_pkg::ctl_t ctl_s1;
	logic [1:0] kind_s1;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic [COORD_WIDTH-2:0] r_s1, hx_s1, hy_s1, hz_s1;
	logic signed [PW-1:0] px_s1, py_s1, pz_s1;
	logic [PW-1:0] bx_s1, by_s1, bz_s1;

	logic signed [SW-1:0] plane_dist, total;
	logic [SW-1:0] lim;
	logic outside;

	fct_pkg::ctl_t ctl_s2;
	logic [1:0] kind_s2;
	logic signed [COORD_WIDTH-1:0] x_s2, y_s2, z_s2;
	logic [COORD_WIDTH-2:0] r_s2, hx_s2, hy_s2, hz_s2;

	// Hold the plane word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_we) begin
			plane_q <= cfg_data;
		end
	end

	// Unpack the plane and form the normal magnitudes
	always_comb begin
		nx = signed'(plane_q[CW-1:0]);
		ny = signed'(plane_q[2*CW-1:CW]);
		nz = signed'(plane_q[3*CW-1:2*CW]);
		dofs = signed'(plane_q[4*CW-1:3*CW]);
		ax = nx[CW-1] ? ((CW+1)'(0) - {nx[CW-1], nx}) : {1'b0, nx};
		ay = ny[CW-1] ? ((CW+1)'(0) - {ny[CW-1], ny}) : {1'b0, ny};
		az = nz[CW-1] ? ((CW+1)'(0) - {nz[CW-1], nz}) : {1'b0, nz};
	end

	// Products of the normal with the center and of its magnitude with the half sizes
	assign px = nx * in_x;
	assign py = ny * in_y;
	assign pz = nz * in_z;
	assign bx = ax * in_hx;
	assign by = ay * in_hy;
	assign bz = az * in_hz;

	// Stage 1: register the products and advance the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= in_kind;
		x_s1 <= in_x;
		y_s1 <= in_y;
		z_s1 <= in_z;
		r_s1 <= in_r;
		hx_s1 <= in_hx;
		hy_s1 <= in_hy;
		hz_s1 <= in_hz;
		px_s1 <= px;
		py_s1 <= py;
		pz_s1 <= pz;
		bx_s1 <= bx;
		by_s1 <= by;
		bz_s1 <= bz;
	end

	// Sum the distance, add the allowed margin and check the sign
	always_comb begin
		plane_dist = SW'(px_s1) + SW'(py_s1) + SW'(pz_s1)
			+ (SW'(dofs) <<< fct_pkg::NORMAL_FRAC);
		case (kind_s1)
			fct_pkg::REQ_SPHERE: lim = SW'(r_s1) << fct_pkg::NORMAL_FRAC;
			fct_pkg::REQ_BOX:    lim = SW'(bx_s1) + SW'(by_s1) + SW'(bz_s1);
			default:             lim = '0;
		endcase
		total = plane_dist + signed'(lim);
		outside = total[SW-1];
	end

	// Stage 2: fold this plane into the running flag and hand the request on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.vld <= ctl_s1.vld;
			ctl_s2.visible <= ctl_s1.visible & ~outside;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		z_s2 <= z_s1;
		r_s2 <= r_s1;
		hx_s2 <= hx_s1;
		hy_s2 <= hy_s1;
		hz_s2 <= hz_s1;
	end

	assign out_ctl = ctl_s2;
	assign out_kind = kind_s2;
	assign out_x = x_s2;
	assign out_y = y_s2;
	assign out_z = z_s2;
	assign out_r = r_s2;
	assign out_hx = hx_s2;
	assign out_hy = hy_s2;
	assign out_hz = hz_s2;

endmodule

// File: hw/rtl/frustum_cull_test_core.sv
// Top level of the frustum cull test core: a chain of six plane cells.
//
// Tests one point, sphere or axis-aligned box per clock against six planes written
// over the configuration channel (index 0 left, 1 right, 2 top, 3 bottom, 4 near,
// 5 far; other indexes are dropped). A request is taken at every clock with start
// high; busy never rises. Each request walks the row of six cells, two register
// stages per cell (products, then sum and sign check), and done pulses for one cycle
// with inside_res when it leaves the last cell, in request order. The receiver has
// no way to stall: capture inside_res in the cycle done is high. cfg_ready is always
// high; write planes only while no request is in flight.
module frustum_cull_test_core #(
	parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           req_type,
	input  logic signed [COORD_WIDTH-1:0]        pos_x,
	input  logic signed [COORD_WIDTH-1:0]        pos_y,
	input  logic signed [COORD_WIDTH-1:0]        pos_z,
	input  logic [COORD_WIDTH-2:0]               radius,
	input  logic [COORD_WIDTH-2:0]               half_x,
	input  logic [COORD_WIDTH-2:0]               half_y,
	input  logic [COORD_WIDTH-2:0]               half_z,
	output logic                                 done,
	output logic                                 inside_res,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fct_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [fct_pkg::PLANE_W-1:0]          cfg_data
);

	localparam int NC = fct_pkg::PLANE_COUNT;

	fct_pkg::ctl_t ctl_c [0:NC];
	logic [1:0] kind_c [0:NC];
	logic signed [COORD_WIDTH-1:0] x_c [0:NC];
	logic signed [COORD_WIDTH-1:0] y_c [0:NC];
	logic signed [COORD_WIDTH-1:0] z_c [0:NC];
	logic [COORD_WIDTH-2:0] r_c [0:NC];
	logic [COORD_WIDTH-2:0] hx_c [0:NC];
	logic [COORD_WIDTH-2:0] hy_c [0:NC];
	logic [COORD_WIDTH-2:0] hz_c [0:NC];

	// Always ready on both channels
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Feed the head of the chain
	always_comb begin
		ctl_c[0].vld = start & ~busy;
		ctl_c[0].visible = 1'b1;
		kind_c[0] = req_type;
		x_c[0] = pos_x;
		y_c[0] = pos_y;
		z_c[0] = pos_z;
		r_c[0] = radius;
		hx_c[0] = half_x;
		hy_c[0] = half_y;
		hz_c[0] = half_z;
	end

	// Row of plane cells
	for (genvar i = 0; i < NC; i++) begin : g_cell
		logic cfg_we;

		assign cfg_we = cfg_valid & cfg_ready &
			(cfg_index == fct_pkg::CFG_INDEX_W'(i));

		fct_cell #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg_we   (cfg_we),
			.cfg_data (cfg_data),
			.in_ctl   (ctl_c[i]),
			.in_kind  (kind_c[i]),
			.in_x     (x_c[i]),
			.in_y     (y_c[i]),
			.in_z     (z_c[i]),
			.in_r     (r_c[i]),
			.in_hx    (hx_c[i]),
			.in_hy    (hy_c[i]),
			.in_hz    (hz_c[i]),
			.out_ctl  (ctl_c[i+1]),
			.out_kind (kind_c[i+1]),
			.out_x    (x_c[i+1]),
			.out_y    (y_c[i+1]),
			.out_z    (z_c[i+1]),
			.out_r    (r_c[i+1]),
			.out_hx   (hx_c[i+1]),
			.out_hy   (hy_c[i+1]),
			.out_hz   (hz_c[i+1])
		);
	end

	// Result from the tail of the chain
	assign done = ctl_c[NC].vld;
	assign inside_res = ctl_c[NC].visible;

endmodule

// File: bench/frustum_cull_check.sv
// Checker for the frustum cull test core: plane shadow, visibility predictor and result compare.
`timescale 1ns / 1ps

module frustum_cull_check #(
	parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic [1:0]                           req_type,
	input  logic signed [COORD_WIDTH-1:0]        pos_x,
	input  logic signed [COORD_WIDTH-1:0]        pos_y,
	input  logic signed [COORD_WIDTH-1:0]        pos_z,
	input  logic [COORD_WIDTH-2:0]               radius,
	input  logic [COORD_WIDTH-2:0]               half_x,
	input  logic [COORD_WIDTH-2:0]               half_y,
	input  logic [COORD_WIDTH-2:0]               half_z,
	input  logic                                 done,
	input  logic                                 inside_res,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [fct_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [fct_pkg::PLANE_W-1:0]          cfg_data,
	output int                                   errors,
	output int                                   pending
);
	import fct_pkg::*;

	logic [PLANE_W-1:0] plane_copy [PLANE_COUNT];
	bit visible_q [$];
	int miss_count = 0;

	assign errors = miss_count;
	assign pending = visible_q.size();

	// Visible unless wholly on the negative side of some plane; exact 64-bit math
	function automatic bit predict_visible(
		input logic [1:0] kind,
		input logic signed [COORD_WIDTH-1:0] x,
		input logic signed [COORD_WIDTH-1:0] y,
		input logic signed [COORD_WIDTH-1:0] z,
		input logic [COORD_WIDTH-2:0] r,
		input logic [COORD_WIDTH-2:0] hx,
		input logic [COORD_WIDTH-2:0] hy,
		input logic [COORD_WIDTH-2:0] hz
	);
		longint xs, ys, zs, rs, hxs, hys, hzs;
		longint nx, ny, nz, d, plane_dist, margin;
		bit vis;
		int p;
		xs = x;
		ys = y;
		zs = z;
		rs = r;
		hxs = hx;
		hys = hy;
		hzs = hz;
		vis = 1'b1;
		for (p = 0; p < PLANE_COUNT; p++) begin
			nx = $signed(plane_copy[p][COEF_W-1:0]);
			ny = $signed(plane_copy[p][2*COEF_W-1:COEF_W]);
			nz = $signed(plane_copy[p][3*COEF_W-1:2*COEF_W]);
			d = $signed(plane_copy[p][4*COEF_W-1:3*COEF_W]);
			plane_dist = nx * xs + ny * ys + nz * zs + (d <<< NORMAL_FRAC);
			case (kind)
				REQ_SPHERE: margin = rs <<< NORMAL_FRAC;
				REQ_BOX: begin
					margin = (nx < 0 ? -nx : nx) * hxs + (ny < 0 ? -ny : ny) * hys
						+ (nz < 0 ? -nz : nz) * hzs;
				end
				// point, and the undefined kind which is tested as a point
				default: margin = 0;
			endcase
			if (plane_dist < -margin)
				vis = 1'b0;
		end
		return vis;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			visible_q.delete();
			for (int p = 0; p < PLANE_COUNT; p++)
				plane_copy[p] = '0;
		end else begin
			// compare each result with the oldest prediction
			if (done) begin
				if (visible_q.size() == 0) begin
					$error("inside_res: expected none, actual %0b", inside_res);
					miss_count++;
				end else begin
					want = visible_q.pop_front();
					if (inside_res !== want) begin
						$error("inside_res: expected %0b, actual %0b", want, inside_res);
						miss_count++;
					end
				end
			end
			// predict on each request transfer
			if (start && !busy)
				visible_q.push_back(predict_visible(req_type, pos_x, pos_y, pos_z,
					radius, half_x, half_y, half_z));
			// shadow plane writes; out-of-range indexes are dropped
			if (cfg_valid && cfg_ready && cfg_index < PLANE_COUNT)
				plane_copy[cfg_index] = cfg_data;
		end
	end

endmodule

// File: bench/tb_frustum_cull_test_core.sv
// Testbench top for the frustum cull test core: reset, plane loads, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_frustum_cull_test_core;
	import fct_pkg::*;

	localparam int COORD_WIDTH = COORD_WIDTH_DEF;
	localparam int PIPE_LAT = 12;
	localparam int RAND_PHASES = 6;
	localparam int RAND_PER_PHASE = 150;

	// plane register indexes
	localparam logic [CFG_INDEX_W-1:0] PL_LEFT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] PL_RIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] PL_TOP = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] PL_BOTTOM = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] PL_NEAR = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] PL_FAR = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_B = 3'd7;

	// request code with no meaning of its own; the core treats it as a point
	localparam logic [1:0] REQ_UNDEF = 2'd3;

	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;
	localparam int UNIT = 16384;
	localparam int CMAX = 32767;
	localparam int CMIN = -32768;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] req_type = '0;
	logic signed [COORD_WIDTH-1:0] pos_x = '0;
	logic signed [COORD_WIDTH-1:0] pos_y = '0;
	logic signed [COORD_WIDTH-1:0] pos_z = '0;
	logic [COORD_WIDTH-2:0] radius = '0;
	logic [COORD_WIDTH-2:0] half_x = '0;
	logic [COORD_WIDTH-2:0] half_y = '0;
	logic [COORD_WIDTH-2:0] half_z = '0;
	logic done;
	logic inside_res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [PLANE_W-1:0] cfg_data = '0;

	int fail_count;
	int in_flight;
	int burst_left = 0;
	int kind_seen [4] = '{0, 0, 0, 0};
	int settings_loaded = 1;
	logic [PLANE_W-1:0] plane_set [PLANE_COUNT];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	frustum_cull_test_core #(.COORD_WIDTH(COORD_WIDTH)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req_type(req_type),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .radius(radius),
		.half_x(half_x), .half_y(half_y), .half_z(half_z), .done(done),
		.inside_res(inside_res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	frustum_cull_check #(.COORD_WIDTH(COORD_WIDTH)) i_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req_type(req_type),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .radius(radius),
		.half_x(half_x), .half_y(half_y), .half_z(half_z), .done(done),
		.inside_res(inside_res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(fail_count),
		.pending(in_flight)
	);

	// Present one request, hold until transfer, then keep the burst going or gap
	task automatic drive_item(input logic [1:0] kind, input int x, input int y, input int z,
		input int r, input int hx, input int hy, input int hz);
		start <= 1'b1;
		req_type <= kind;
		pos_x <= x[COORD_WIDTH-1:0];
		pos_y <= y[COORD_WIDTH-1:0];
		pos_z <= z[COORD_WIDTH-1:0];
		radius <= r[COORD_WIDTH-2:0];
		half_x <= hx[COORD_WIDTH-2:0];
		half_y <= hy[COORD_WIDTH-2:0];
		half_z <= hz[COORD_WIDTH-2:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		kind_seen[kind]++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
				: $urandom_range(0, 6);
		end
	endtask

	// Random request, either near the frustum faces or anywhere in the field ranges
	task automatic send_random(input bit near);
		logic [1:0] kind;
		int x, y, z, r, hx, hy, hz;
		case ($urandom_range(0, 9))
			0: kind = REQ_UNDEF;
			1, 2, 3: kind = REQ_POINT;
			4, 5, 6: kind = REQ_SPHERE;
			default: kind = REQ_BOX;
		endcase
		if (near) begin
			x = $urandom_range(0, 12000) - 6000;
			y = $urandom_range(0, 12000) - 6000;
			z = $urandom_range(0, 12000) - 6000;
			r = $urandom_range(0, 2500);
			hx = $urandom_range(0, 2500);
			hy = $urandom_range(0, 2500);
			hz = $urandom_range(0, 2500);
		end else begin
			x = $urandom;
			y = $urandom;
			z = $urandom;
			r = $urandom;
			hx = $urandom;
			hy = $urandom;
			hz = $urandom;
		end
		drive_item(kind, x, y, z, r, hx, hy, hz);
	endtask

	// Drop the request line and wait until every result is back and the pipe is empty
	task automatic settle();
		start <= 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	// Write all six planes, then poke both unused indexes with junk
	task automatic load_planes();
		int p;
		for (p = 0; p < PLANE_COUNT + 2; p++) begin
			cfg_valid <= 1'b1;
			if (p < PLANE_COUNT) begin
				cfg_index <= p[CFG_INDEX_W-1:0];
				cfg_data <= plane_set[p];
			end else begin
				cfg_index <= (p == PLANE_COUNT) ? IDX_SPARE_A : IDX_SPARE_B;
				cfg_data <= {$urandom, $urandom};
			end
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// One face of an axis-aligned box frustum, with optional tilt and offset jitter
	function automatic logic [PLANE_W-1:0] axis_plane(input int axis, input bit neg,
		input int reach, input int jit);
		int nv [3];
		int dv;
		int k;
		for (k = 0; k < 3; k++)
			nv[k] = (jit > 0) ? $urandom_range(0, 2 * jit) - jit : 0;
		nv[axis] = nv[axis] + (neg ? -UNIT : UNIT);
		dv = reach + ((jit > 0) ? $urandom_range(0, jit) : 0);
		return {dv[COEF_W-1:0], nv[2][COEF_W-1:0], nv[1][COEF_W-1:0], nv[0][COEF_W-1:0]};
	endfunction

	task automatic set_axis_frustum(input int reach, input int jit);
		plane_set[PL_LEFT] = axis_plane(AX_X, 1'b0, reach, jit);
		plane_set[PL_RIGHT] = axis_plane(AX_X, 1'b1, reach, jit);
		plane_set[PL_TOP] = axis_plane(AX_Y, 1'b1, reach, jit);
		plane_set[PL_BOTTOM] = axis_plane(AX_Y, 1'b0, reach, jit);
		plane_set[PL_NEAR] = axis_plane(AX_Z, 1'b0, reach, jit);
		plane_set[PL_FAR] = axis_plane(AX_Z, 1'b1, reach, jit);
	endtask

	task automatic fill_planes(input logic [PLANE_W-1:0] word);
		int p;
		for (p = 0; p < PLANE_COUNT; p++)
			plane_set[p] = word;
		load_planes();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("frustum_cull_test_core regression: fail");
		$finish;
	end

	initial begin
		int ph, i, mode;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		@(posedge clk);

		// planes still at reset: every distance is zero, all visible
		drive_item(REQ_POINT, CMAX, CMIN, CMAX, 0, 0, 0, 0);
		drive_item(REQ_SPHERE, CMIN, CMAX, CMIN, CMAX, 0, 0, 0);
		drive_item(REQ_BOX, 0, 0, 0, 0, CMAX, CMAX, CMAX);
		drive_item(REQ_UNDEF, -1, -1, -1, CMAX, CMAX, CMAX, CMAX);
		settle();

		// exact unit box frustum: probe on-plane and one-step-off cases
		set_axis_frustum(1600, 0);
		load_planes();
		drive_item(REQ_POINT, 0, 0, 0, 0, 0, 0, 0);
		drive_item(REQ_POINT, -1600, 0, 0, 0, 0, 0, 0);
		drive_item(REQ_POINT, -1601, 0, 0, 0, 0, 0, 0);
		drive_item(REQ_SPHERE, -1700, 0, 0, 100, 0, 0, 0);
		drive_item(REQ_SPHERE, -1700, 0, 0, 99, 0, 0, 0);
		drive_item(REQ_BOX, 0, 0, 1650, 0, 0, 0, 50);
		drive_item(REQ_BOX, 0, 0, 1650, 0, 0, 0, 49);
		drive_item(REQ_UNDEF, -1601, 0, 0, CMAX, CMAX, CMAX, CMAX);
		drive_item(REQ_SPHERE, 0, 1601, 0, 0, CMAX, CMAX, CMAX);
		settle();

		// coefficient extremes, non-unit normals
		fill_planes({4{16'h8000}});
		drive_item(REQ_POINT, CMIN, CMIN, CMIN, 0, 0, 0, 0);
		drive_item(REQ_SPHERE, CMAX, CMAX, CMAX, CMAX, 0, 0, 0);
		drive_item(REQ_BOX, 0, 0, 0, 0, CMAX, CMAX, CMAX);
		settle();
		fill_planes({4{16'h7FFF}});
		drive_item(REQ_POINT, CMAX, CMAX, CMAX, 0, 0, 0, 0);
		drive_item(REQ_SPHERE, CMIN, CMIN, CMIN, CMAX, 0, 0, 0);
		drive_item(REQ_BOX, CMIN, CMIN, CMIN, 0, CMAX, CMAX, CMAX);
		settle();
		fill_planes({4{16'hFFFF}});
		drive_item(REQ_POINT, 1, 1, 1, 0, 0, 0, 0);
		drive_item(REQ_BOX, -1, -1, -1, 0, 1, 1, 1);

		// random phases: jittered frustums, raw plane words, and a mix of both
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			mode = ph % 3;
			if (mode == 1) begin
				for (i = 0; i < PLANE_COUNT; i++)
					plane_set[i] = {$urandom, $urandom};
			end else begin
				set_axis_frustum($urandom_range(200, 4000), $urandom_range(0, 1200));
				if (mode == 2)
					plane_set[$urandom_range(0, PLANE_COUNT - 1)] = {$urandom, $urandom};
			end
			load_planes();
			for (i = 0; i < RAND_PER_PHASE; i++)
				send_random((mode == 1) ? ($urandom_range(0, 3) == 0)
					: ($urandom_range(0, 4) != 0));
		end
		settle();

		$display("covered %0d requests: %0d point, %0d sphere, %0d box, %0d undefined kind",
			kind_seen[REQ_POINT] + kind_seen[REQ_SPHERE] + kind_seen[REQ_BOX]
			+ kind_seen[REQ_UNDEF], kind_seen[REQ_POINT], kind_seen[REQ_SPHERE],
			kind_seen[REQ_BOX], kind_seen[REQ_UNDEF]);
		$display("plane settings used: %0d (reset, exact frustum, extremes, random)",
			settings_loaded);
		if (fail_count == 0 && in_flight == 0)
			$display("frustum_cull_test_core regression: pass");
		else
			$display("frustum_cull_test_core regression: fail");
		$finish;
	end

endmodule
